// ===== hw/rtl/i8080_alu_flags_core_defines.svh =====
// Assertion macros shared by the accumulator and flag unit.
`ifndef I8080_ALU_FLAGS_CORE_DEFINES_SVH
`define I8080_ALU_FLAGS_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define I80AF_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("i80af assertion failed");

`define I80AF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i80af assertion failed");

`else

`define I80AF_ASSERT(lbl, expr)

`define I80AF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/i80af_pkg.sv =====
// Types, operation codes and constants of the 8080 accumulator and flag unit.
`default_nettype none

package i80af_pkg;

  localparam int unsigned OP_W        = 5;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam op_t OP_ADD  = 5'd0;
  localparam op_t OP_ADC  = 5'd1;
  localparam op_t OP_SUB  = 5'd2;
  localparam op_t OP_SBB  = 5'd3;
  localparam op_t OP_AND  = 5'd4;
  localparam op_t OP_XOR  = 5'd5;
  localparam op_t OP_OR   = 5'd6;
  localparam op_t OP_CMP  = 5'd7;
  localparam op_t OP_INC  = 5'd8;
  localparam op_t OP_DEC  = 5'd9;
  localparam op_t OP_RLC  = 5'd10;
  localparam op_t OP_RRC  = 5'd11;
  localparam op_t OP_RAL  = 5'd12;
  localparam op_t OP_RAR  = 5'd13;
  localparam op_t OP_DAA  = 5'd14;
  localparam op_t OP_CMA  = 5'd15;
  localparam op_t OP_CMC  = 5'd16;
  localparam op_t OP_STC  = 5'd17;
  localparam op_t OP_LOAD = 5'd18;

  localparam logic [3:0] BCD_MAX    = 4'd9;
  localparam byte_t      DAA_LO_ADJ = 8'h06;
  localparam byte_t      DAA_HI_ADJ = 8'h60;

  typedef struct packed {
    byte_t acc;
    logic  cy;
    logic  ac;
    logic  z;
    logic  s;
    logic  p;
  } alu_state_t;

  function automatic byte_t flag_byte(alu_state_t st);
    return {st.s, st.z, 1'b0, st.ac, 1'b0, st.p, 1'b1, st.cy};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i80af_alu.sv =====
// Combinational datapath: computes the next accumulator, flags and raw value for one word.
`default_nettype none

module i80af_alu (
  input  wire i80af_pkg::op_t      op,
  input  wire i80af_pkg::byte_t    operand,
  input  wire i80af_pkg::byte_t    load_val,
  input  wire i80af_pkg::alu_state_t state_i,
  output i80af_pkg::alu_state_t    state_o,
  output i80af_pkg::byte_t         value_o
);

  function automatic i80af_pkg::alu_state_t with_zsp(i80af_pkg::alu_state_t st,
                                                     i80af_pkg::byte_t v);
    i80af_pkg::alu_state_t r;
    r   = st;
    r.z = (v == '0);
    r.s = v[7];
    r.p = ~^v;
    return r;
  endfunction

  i80af_pkg::byte_t a;
  logic             add_cin;
  logic             sub_bin;
  logic [8:0]       add_sum9;
  logic [4:0]       add_nib5;
  logic [8:0]       sub_rhs9;
  logic [4:0]       sub_rhs5;
  i80af_pkg::byte_t sub_diff;
  logic             sub_cy;
  logic             sub_ac;
  i80af_pkg::byte_t inc_val;
  i80af_pkg::byte_t dec_val;
  logic             daa_lo_fix;
  i80af_pkg::byte_t daa_a1;
  logic             daa_ac1;
  logic             daa_hi_fix;
  logic [8:0]       daa_sum9;
  i80af_pkg::byte_t daa_a2;
  logic             daa_cy;
  logic             daa_ac;

  assign a       = state_i.acc;
  assign add_cin = (op == i80af_pkg::OP_ADC) & state_i.cy;
  assign sub_bin = (op == i80af_pkg::OP_SBB) & state_i.cy;

  assign add_sum9 = {1'b0, a} + {1'b0, operand} + {8'd0, add_cin};
  assign add_nib5 = {1'b0, a[3:0]} + {1'b0, operand[3:0]} + {4'd0, add_cin};

  assign sub_rhs9 = {1'b0, operand} + {8'd0, sub_bin};
  assign sub_rhs5 = {1'b0, operand[3:0]} + {4'd0, sub_bin};
  assign sub_diff = a - sub_rhs9[7:0];
  assign sub_cy   = ({1'b0, a} < sub_rhs9);
  assign sub_ac   = ({1'b0, a[3:0]} < sub_rhs5);

  assign inc_val = operand + 8'd1;
  assign dec_val = operand - 8'd1;

  assign daa_lo_fix = state_i.ac | (a[3:0] > i80af_pkg::BCD_MAX);
  assign daa_a1     = daa_lo_fix ? (a + i80af_pkg::DAA_LO_ADJ) : a;
  assign daa_ac1    = daa_lo_fix ? (a[3:0] > i80af_pkg::BCD_MAX) : state_i.ac;
  assign daa_hi_fix = state_i.cy | (daa_a1[7:4] > i80af_pkg::BCD_MAX);
  assign daa_sum9   = {1'b0, daa_a1} + {1'b0, i80af_pkg::DAA_HI_ADJ};
  assign daa_a2     = daa_hi_fix ? daa_sum9[7:0] : daa_a1;
  assign daa_cy     = state_i.cy | (daa_hi_fix & daa_sum9[8]);
  assign daa_ac     = daa_hi_fix ? 1'b0 : daa_ac1;

  always_comb begin
    state_o = state_i;
    value_o = a;
    case (op)
      i80af_pkg::OP_ADD, i80af_pkg::OP_ADC: begin
        state_o     = with_zsp(state_i, add_sum9[7:0]);
        state_o.acc = add_sum9[7:0];
        state_o.cy  = add_sum9[8];
        state_o.ac  = add_nib5[4];
        value_o     = add_sum9[7:0];
      end
      i80af_pkg::OP_SUB, i80af_pkg::OP_SBB: begin
        state_o     = with_zsp(state_i, sub_diff);
        state_o.acc = sub_diff;
        state_o.cy  = sub_cy;
        state_o.ac  = sub_ac;
        value_o     = sub_diff;
      end
      i80af_pkg::OP_CMP: begin
        state_o    = with_zsp(state_i, sub_diff);
        state_o.cy = sub_cy;
        state_o.ac = sub_ac;
        value_o    = sub_diff;
      end
      i80af_pkg::OP_AND: begin
        state_o     = with_zsp(state_i, a & operand);
        state_o.acc = a & operand;
        state_o.cy  = 1'b0;
        value_o     = a & operand;
      end
      i80af_pkg::OP_XOR: begin
        state_o     = with_zsp(state_i, a ^ operand);
        state_o.acc = a ^ operand;
        state_o.cy  = 1'b0;
        value_o     = a ^ operand;
      end
      i80af_pkg::OP_OR: begin
        state_o     = with_zsp(state_i, a | operand);
        state_o.acc = a | operand;
        state_o.cy  = 1'b0;
        value_o     = a | operand;
      end
      i80af_pkg::OP_INC: begin
        state_o = with_zsp(state_i, inc_val);
        value_o = inc_val;
      end
      i80af_pkg::OP_DEC: begin
        state_o = with_zsp(state_i, dec_val);
        value_o = dec_val;
      end
      i80af_pkg::OP_RLC: begin
        state_o.cy  = a[7];
        state_o.acc = {a[6:0], a[7]};
        value_o     = {a[6:0], a[7]};
      end
      i80af_pkg::OP_RRC: begin
        state_o.cy  = a[0];
        state_o.acc = {a[0], a[7:1]};
        value_o     = {a[0], a[7:1]};
      end
      i80af_pkg::OP_RAL: begin
        state_o.cy  = a[7];
        state_o.acc = {a[6:0], state_i.cy};
        value_o     = {a[6:0], state_i.cy};
      end
      i80af_pkg::OP_RAR: begin
        state_o.cy  = a[0];
        state_o.acc = {state_i.cy, a[7:1]};
        value_o     = {state_i.cy, a[7:1]};
      end
      i80af_pkg::OP_DAA: begin
        state_o     = with_zsp(state_i, daa_a2);
        state_o.acc = daa_a2;
        state_o.cy  = daa_cy;
        state_o.ac  = daa_ac;
        value_o     = daa_a2;
      end
      i80af_pkg::OP_CMA: begin
        state_o.acc = ~a;
        value_o     = ~a;
      end
      i80af_pkg::OP_CMC: begin
        state_o.cy = ~state_i.cy;
      end
      i80af_pkg::OP_STC: begin
        state_o.cy = 1'b1;
      end
      i80af_pkg::OP_LOAD: begin
        state_o.acc = load_val;
        state_o.cy  = operand[0];
        state_o.p   = operand[2];
        state_o.ac  = operand[4];
        state_o.z   = operand[6];
        state_o.s   = operand[7];
        value_o     = load_val;
      end
      default: begin
        state_o = state_i;
        value_o = a;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i8080_alu_flags_core.sv =====
// Top level of the 8080 accumulator and flag unit: input register, datapath and result register.
//
//   Channel  Direction  tdata fields (low bit up)
//   in_*     slave      req_type[4:0], operand[12:5], acc_load_value[20:13], zeros
//   out_*    master     acc_out[7:0], flag_byte[15:8], value_out[23:16]
//
// A word is held in the input register and then sits in the result register. One word is
// accepted per cycle unless the result stalls; the accumulator and flags update as a word leaves
// the input register, so each word sees the state left by the one before it.
// Reset clears the accumulator, all flags and both valid bits.
// A stalled result holds the input register, and in_tready drops only while both are full.
`default_nettype none
`include "i8080_alu_flags_core_defines.svh"

module i8080_alu_flags_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // req_type, operand, acc_load_value, zero fill
  input  wire [i80af_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // acc_out, flag_byte, value_out
  output logic [i80af_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic                       in_valid_r;
  logic                       in_valid_nxt;
  i80af_pkg::op_t             op_r;
  i80af_pkg::byte_t           operand_r;
  i80af_pkg::byte_t           load_val_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [i80af_pkg::OUT_TDATA_W-1:0] out_data_r;
  i80af_pkg::alu_state_t      state_r;
  i80af_pkg::alu_state_t      state_nxt;
  i80af_pkg::byte_t           value;
  logic                       advance;
  logic                       in_fire;

  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;
  assign in_fire   = in_tvalid & in_tready;

  assign in_valid_nxt  = in_fire | (in_valid_r & ~advance);
  assign out_valid_nxt = advance | (out_valid_r & ~out_tready);

  i80af_alu u_alu (
    .op       (op_r),
    .operand  (operand_r),
    .load_val (load_val_r),
    .state_i  (state_r),
    .state_o  (state_nxt),
    .value_o  (value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= in_tdata[4:0];
      operand_r  <= in_tdata[12:5];
      load_val_r <= in_tdata[20:13];
    end
    if (advance) begin
      out_data_r <= {value, i80af_pkg::flag_byte(state_nxt), state_nxt.acc};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `I80AF_ASSERT(a_flag_fixed_bits,
    !out_tvalid || (out_tdata[9] && !out_tdata[11] && !out_tdata[13]))
  `I80AF_ASSERT_NEXT(a_state_holds_without_advance, !advance, $stable(state_r))
  `I80AF_ASSERT_NEXT(a_result_matches_state, advance,
    out_tdata[7:0] == state_r.acc && out_tdata[15:8] == i80af_pkg::flag_byte(state_r))

endmodule

`default_nettype wire
